FILE: src/wgit_pkg.sv
// wgit_pkg: shared constants and the controller-to-datapath command type
// of the winograd input tile transform; no dependencies
`timescale 1ns / 1ps

package wgit_pkg;

  // tile geometry
  localparam int NCOL      = 6;
  localparam int COEF_BITS = 21;
  localparam int IDX_BITS  = 3;
  localparam int OUT_TDATA_W = ((NCOL * COEF_BITS + 7) / 8) * 8;

  // Q2.14 constants of the Bt pass
  localparam int K_M5_2    = -40960;
  localparam int K_SQ2     = 23170;
  localparam int K_M_SQ2   = -23170;
  localparam int K_SQ2_2   = 11585;
  localparam int K_M_SQ2_2 = -11585;
  localparam int K_M2      = -32768;
  localparam int K_M1_2    = -8192;
  localparam int ROUND_HALF = 8192;
  localparam int Q_SHIFT    = 14;

  // counter marks
  localparam logic [IDX_BITS-1:0] LAST_ROW       = 3'd5;
  localparam logic [IDX_BITS-1:0] COL_FIRST_DONE = 3'd2;
  localparam logic [IDX_BITS-1:0] COL_LAST_STEP  = 3'd7;

  typedef struct packed {
    logic                load_in;    // operands from the input item
    logic                wr_row;     // row pass result into the tile store
    logic [IDX_BITS-1:0] wr_idx;     // tile store row
    logic                load_col;   // operands from the next store column
    logic                shift_ob;   // column pass result into the output buffer
    logic                shift_out;  // output row taken, advance the buffer
  } cmd_t;

endpackage

FILE: src/wgit_bt.sv
// wgit_bt: one Bt pass over six values, constant products registered,
// rounding and butterfly sums after the register; uses wgit_pkg
`timescale 1ns / 1ps

module wgit_bt #(
  parameter int IW = 20
) (
  input  logic                clk,
  input  logic signed [IW-1:0] op  [wgit_pkg::NCOL],
  output logic signed [IW+3:0] res [wgit_pkg::NCOL]
);

  localparam int PW = IW + 18;
  localparam int OW = IW + 4;

  logic signed [PW-1:0] m52_i2_r, msq2_i1_r, sq22_i3_r, m2_i2_r;
  logic signed [PW-1:0] sq2_i3_r, msq22_i1_r, m12_i2_r, m52_i3_r;
  logic signed [IW-1:0] i0_r, i1_r, i4_r, i5_r;
  logic signed [OW-1:0] t_a, t_b, t_c, t_d;

  // x*k + 2^13, arithmetic shift by 14
  function automatic logic signed [OW-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = (p + PW'(wgit_pkg::ROUND_HALF)) >>> wgit_pkg::Q_SHIFT;
    return OW'(s);
  endfunction

  always_ff @(posedge clk) begin
    m52_i2_r   <= PW'(op[2]) * PW'(wgit_pkg::K_M5_2);
    msq2_i1_r  <= PW'(op[1]) * PW'(wgit_pkg::K_M_SQ2);
    sq22_i3_r  <= PW'(op[3]) * PW'(wgit_pkg::K_SQ2_2);
    m2_i2_r    <= PW'(op[2]) * PW'(wgit_pkg::K_M2);
    sq2_i3_r   <= PW'(op[3]) * PW'(wgit_pkg::K_SQ2);
    msq22_i1_r <= PW'(op[1]) * PW'(wgit_pkg::K_M_SQ2_2);
    m12_i2_r   <= PW'(op[2]) * PW'(wgit_pkg::K_M1_2);
    m52_i3_r   <= PW'(op[3]) * PW'(wgit_pkg::K_M5_2);
    i0_r <= op[0];
    i1_r <= op[1];
    i4_r <= op[4];
    i5_r <= op[5];
  end

  always_comb begin
    t_a = rnd(msq2_i1_r) + rnd(sq22_i3_r);
    t_b = rnd(m2_i2_r) + OW'(i4_r);
    t_c = rnd(sq2_i3_r) + rnd(msq22_i1_r);
    t_d = rnd(m12_i2_r) + OW'(i4_r);
    res[0] = OW'(i0_r) + rnd(m52_i2_r) + OW'(i4_r);
    res[1] = t_a + t_b;
    res[2] = t_b - t_a;
    res[3] = t_c + t_d;
    res[4] = t_d - t_c;
    res[5] = OW'(i1_r) + rnd(m52_i3_r) + OW'(i5_r);
  end

endmodule

FILE: src/wgit_ctrl.sv
// wgit_ctrl: sequencer for row passes, the column sweep and row output
// uses wgit_pkg; drives the datapath through wgit_pkg::cmd_t
`timescale 1ns / 1ps

module wgit_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic                          out_tlast,
  output logic [wgit_pkg::IDX_BITS-1:0] out_tuser,
  output wgit_pkg::cmd_t                cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RMUL = 5'b00010,
    S_RWR  = 5'b00100,
    S_COL  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [wgit_pkg::IDX_BITS-1:0] cnt_r, cnt_nxt;

  always_comb begin
    in_tready  = (state_r == S_IDLE);
    out_tvalid = (state_r == S_OUT);
    out_tuser  = cnt_r;
    out_tlast  = out_tvalid && (cnt_r == wgit_pkg::LAST_ROW);

    cmd.load_in   = in_tvalid && in_tready;
    cmd.wr_row    = (state_r == S_RWR);
    cmd.wr_idx    = cnt_r;
    // column loads on steps 0..5, results into the output buffer on steps 2..7
    cmd.load_col  = (state_r == S_COL) && (cnt_r <= wgit_pkg::LAST_ROW);
    cmd.shift_ob  = (state_r == S_COL) && (cnt_r >= wgit_pkg::COL_FIRST_DONE);
    cmd.shift_out = out_tvalid && out_tready;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load_in) state_nxt = S_RMUL;
      end
      S_RMUL: begin
        state_nxt = S_RWR;
      end
      S_RWR: begin
        if (cnt_r == wgit_pkg::LAST_ROW) begin
          state_nxt = S_COL;
          cnt_nxt   = '0;
        end else begin
          state_nxt = S_IDLE;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      S_COL: begin
        if (cnt_r == wgit_pkg::COL_LAST_STEP) begin
          state_nxt = S_OUT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_OUT: begin
        if (cmd.shift_out) begin
          if (cnt_r == wgit_pkg::LAST_ROW) begin
            state_nxt = S_IDLE;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: src/wgit_dp.sv
// wgit_dp: operand register, shared Bt unit, 6x6 tile store and output buffer
// uses wgit_pkg and wgit_bt; steered by wgit_ctrl commands
`timescale 1ns / 1ps

module wgit_dp #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic [((6*SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,
  input  wgit_pkg::cmd_t                         cmd,
  output logic [wgit_pkg::OUT_TDATA_W-1:0]       out_tdata
);

  localparam int SW = SAMPLE_BITS + 4;
  localparam int CW = SW + 4;
  localparam int NC = wgit_pkg::NCOL;
  localparam int KB = wgit_pkg::COEF_BITS;

  logic signed [SW-1:0] op_r    [NC];
  logic signed [CW-1:0] res     [NC];
  logic signed [SW-1:0] store_r [NC][NC];
  logic signed [KB-1:0] ob_r    [NC][NC];

  wgit_bt #(.IW(SW)) u_bt (
    .clk (clk),
    .op  (op_r),
    .res (res)
  );

  always_ff @(posedge clk) begin
    for (int j = 0; j < NC; j++) begin
      if (cmd.load_in) begin
        op_r[j] <= SW'($signed(in_tdata[j*SAMPLE_BITS +: SAMPLE_BITS]));
      end else if (cmd.load_col) begin
        op_r[j] <= store_r[j][0];
      end
    end
  end

  // store rows hold row pass results; the column sweep rotates each row left
  always_ff @(posedge clk) begin
    if (cmd.wr_row) begin
      for (int j = 0; j < NC; j++) store_r[cmd.wr_idx][j] <= SW'(res[j]);
    end else if (cmd.load_col) begin
      for (int r = 0; r < NC; r++) begin
        for (int j = 0; j < NC - 1; j++) store_r[r][j] <= store_r[r][j+1];
        store_r[r][NC-1] <= store_r[r][0];
      end
    end
  end

  // column results enter on the right, rows leave from the top
  always_ff @(posedge clk) begin
    if (cmd.shift_ob) begin
      for (int r = 0; r < NC; r++) begin
        for (int j = 0; j < NC - 1; j++) ob_r[r][j] <= ob_r[r][j+1];
        ob_r[r][NC-1] <= KB'(res[r]);
      end
    end else if (cmd.shift_out) begin
      for (int r = 0; r < NC - 1; r++) ob_r[r] <= ob_r[r+1];
    end
  end

  always_comb begin
    out_tdata = '0;
    for (int j = 0; j < NC; j++) out_tdata[j*KB +: KB] = ob_r[0][j];
  end

endmodule

FILE: src/winograd_input_tile_transform.sv
// winograd_input_tile_transform: top level of the F(4x4,3x3) input transform
// depends on wgit_pkg, wgit_ctrl, wgit_dp (and wgit_bt below it)
`timescale 1ns / 1ps

// Usage
//   in_*  : one tile row per item, six signed Q8.8 samples. Six items make a
//           tile; the first five produce nothing, the sixth starts the output.
//   out_* : six items per tile, one row of V = Bt*d*B each, six signed 21-bit
//           coefficients, row number on out_tuser, out_tlast on row 5.
// Timing
//   each input row passes the shared Bt unit through operand register,
//   product register and store write; in_tready drops meanwhile.
//   after the sixth row the column sweep runs six column loads through the
//   operand register and the Bt unit, then the six rows are offered.
//   with the one Bt unit and the single tile store, a new tile waits until
//   the last row of the previous tile has gone.
// Reset
//   rst_n low at a clock edge returns to waiting for row 0 of a new tile.
// Stall
//   while out_tready is low the current row holds on out_tdata and no input
//   is taken until the last row of the tile has gone.
module winograd_input_tile_transform #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // sample_0 .. sample_5, SAMPLE_BITS each, zero pad on top
  input  logic [((6*SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // coef_0 .. coef_5, 21 bits each, zero pad on top
  output logic [wgit_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // row_index
  output logic [wgit_pkg::IDX_BITS-1:0]          out_tuser,
  output logic                                   out_tlast
);

  wgit_pkg::cmd_t cmd;

  wgit_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cmd        (cmd)
  );

  wgit_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk       (clk),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .out_tdata (out_tdata)
  );

  // input and output phases never overlap
  a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_tvalid && in_tready))
    else $error("input taken while output rows pending");

  // the load_in, wr_row, load_col and shift_out commands are exclusive
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_in, cmd.wr_row, cmd.load_col, cmd.shift_out}))
    else $error("conflicting datapath commands");

  // the flagged row is row five
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser == wgit_pkg::LAST_ROW)
    else $error("last flag on wrong row");

  // once the last row is taken the block waits for a new tile
  a_tile_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready && !out_tvalid)
    else $error("not idle after tile output");

endmodule
